### hw/rtl/bqe_pkg.sv
// Shared types and constants of the billboard quad expander.
package bqe_pkg;

   localparam int CoordWidth  = 32;
   localparam int TexWidth    = 16;
   localparam int SlotWidth   = 10;
   localparam int VFillWidth  = 10;
   localparam int IFillWidth  = 12;

   localparam logic [VFillWidth-1:0] QUAD_VERTS   = VFillWidth'(4);
   localparam logic [IFillWidth-1:0] QUAD_INDICES = IFillWidth'(6);

   // Corner codes, in the order the corners leave the block.
   localparam logic [1:0] CORNER_PLUS_PLUS   = 2'd0;
   localparam logic [1:0] CORNER_MINUS_PLUS  = 2'd1;
   localparam logic [1:0] CORNER_MINUS_MINUS = 2'd2;
   localparam logic [1:0] CORNER_PLUS_MINUS  = 2'd3;

   typedef struct packed {
      logic signed [CoordWidth-1:0] centre_x;
      logic signed [CoordWidth-1:0] centre_y;
      logic signed [CoordWidth-1:0] centre_z;
      logic signed [CoordWidth-1:0] side_x;
      logic signed [CoordWidth-1:0] side_y;
      logic signed [CoordWidth-1:0] side_z;
      logic signed [CoordWidth-1:0] rise_x;
      logic signed [CoordWidth-1:0] rise_y;
      logic signed [CoordWidth-1:0] rise_z;
      logic [31:0]                  rgba_word;
      logic [31:0]                  tex_s_pair;
      logic [31:0]                  tex_t_pair;
   } bqe_req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] pos_x;
      logic signed [CoordWidth-1:0] pos_y;
      logic signed [CoordWidth-1:0] pos_z;
      logic signed [TexWidth-1:0]   tex_s;
      logic signed [TexWidth-1:0]   tex_t;
      logic [31:0]                  vertex_rgba;
      logic                         tri_valid;
      logic [SlotWidth-1:0]         tri_first;
      logic [SlotWidth-1:0]         tri_second;
      logic [SlotWidth-1:0]         tri_third;
      logic                         restarted;
      logic                         last_corner;
   } bqe_rsp_type;

   // Per-corner control handed from the sequencer to the corner builder.
   typedef struct packed {
      logic [1:0]            corner;
      logic [SlotWidth-1:0]  base;
      logic                  restart;
   } bqe_ctl_type;

endpackage

### hw/rtl/bqe_corner.sv
// Builds one corner vertex of a quad from the held sprite and the corner code.
module bqe_corner (
   input  bqe_pkg::bqe_req_type sprite,
   input  bqe_pkg::bqe_ctl_type ctl,
   output bqe_pkg::bqe_rsp_type corner_out
);
   import bqe_pkg::*;

   localparam int SumWidth = CoordWidth + 2;

   logic add_side;
   logic add_rise;

   function automatic logic [CoordWidth-1:0] corner_sum(
      input logic signed [CoordWidth-1:0] centre,
      input logic signed [CoordWidth-1:0] side,
      input logic signed [CoordWidth-1:0] rise,
      input logic                         plus_side,
      input logic                         plus_rise
   );
      logic signed [SumWidth-1:0] c_ext;
      logic signed [SumWidth-1:0] s_ext;
      logic signed [SumWidth-1:0] r_ext;
      logic signed [SumWidth-1:0] total;
      logic [CoordWidth-1:0]      result;
      c_ext = SumWidth'(centre);
      s_ext = plus_side ? SumWidth'(side) : -SumWidth'(side);
      r_ext = plus_rise ? SumWidth'(rise) : -SumWidth'(rise);
      total = c_ext + s_ext + r_ext;
      // The three top bits agree exactly when the sum fits in 32 bits.
      if (total[SumWidth-1:CoordWidth-1] == '0 || total[SumWidth-1:CoordWidth-1] == '1) begin
         result = total[CoordWidth-1:0];
      end else if (total[SumWidth-1]) begin
         result = {1'b1, {(CoordWidth-1){1'b0}}};
      end else begin
         result = {1'b0, {(CoordWidth-1){1'b1}}};
      end
      return result;
   endfunction

   always_comb begin
      add_side = (ctl.corner == CORNER_PLUS_PLUS) || (ctl.corner == CORNER_PLUS_MINUS);
      add_rise = (ctl.corner == CORNER_PLUS_PLUS) || (ctl.corner == CORNER_MINUS_PLUS);

      corner_out.pos_x = corner_sum(sprite.centre_x, sprite.side_x, sprite.rise_x,
                                    add_side, add_rise);
      corner_out.pos_y = corner_sum(sprite.centre_y, sprite.side_y, sprite.rise_y,
                                    add_side, add_rise);
      corner_out.pos_z = corner_sum(sprite.centre_z, sprite.side_z, sprite.rise_z,
                                    add_side, add_rise);

      corner_out.tex_s = add_side ? sprite.tex_s_pair[15:0] : sprite.tex_s_pair[31:16];
      corner_out.tex_t = add_rise ? sprite.tex_t_pair[15:0] : sprite.tex_t_pair[31:16];
      corner_out.vertex_rgba = sprite.rgba_word;

      corner_out.tri_valid   = 1'b0;
      corner_out.tri_first   = '0;
      corner_out.tri_second  = '0;
      corner_out.tri_third   = '0;
      corner_out.restarted   = 1'b0;
      corner_out.last_corner = 1'b0;

      case (ctl.corner)
         CORNER_PLUS_PLUS: begin
            corner_out.tri_valid  = 1'b1;
            corner_out.tri_first  = ctl.base;
            corner_out.tri_second = ctl.base + SlotWidth'(1);
            corner_out.tri_third  = ctl.base + SlotWidth'(3);
            corner_out.restarted  = ctl.restart;
         end
         CORNER_MINUS_PLUS: begin
            corner_out.tri_valid  = 1'b1;
            corner_out.tri_first  = ctl.base + SlotWidth'(3);
            corner_out.tri_second = ctl.base + SlotWidth'(1);
            corner_out.tri_third  = ctl.base + SlotWidth'(2);
         end
         CORNER_PLUS_MINUS: begin
            corner_out.last_corner = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

### hw/rtl/billboard_quad_expander_top.sv
// Billboard quad expander: one sprite beat in, four corner vertex beats out.
//
//   channel | ports                               | beat
//   --------+-------------------------------------+------------------------------
//   sprite  | req_valid, req_stall, req_payload   | one sprite (centre, axes, colour)
//   vertex  | rsp_valid, rsp_stall, rsp_payload   | one corner vertex with triangles
//
// A sprite is held in an input register and one corner per cycle, unless the vertex
// side stalls, is built from it into the output register. A sprite beat passes through
// the input register and then the output register before its first corner appears.
// The next sprite is taken in the cycle the fourth corner is loaded.
// A stall on the vertex side holds the output register and the corner counter.
// Reset clears the valid flags, the corner counter and both fill counts.
module billboard_quad_expander_top #(
   parameter int VERTEX_CAPACITY = 1024,
   parameter int INDEX_CAPACITY  = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bqe_pkg::bqe_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bqe_pkg::bqe_rsp_type rsp_payload
);
   import bqe_pkg::*;

   localparam logic [VFillWidth:0] VCap = (VFillWidth+1)'(VERTEX_CAPACITY);
   localparam logic [IFillWidth:0] ICap = (IFillWidth+1)'(INDEX_CAPACITY);

   bqe_req_type           sprite_ff, sprite_in;
   logic                  sprite_valid_ff, sprite_valid_in;
   logic [1:0]            corner_ff, corner_in;
   logic [SlotWidth-1:0]  base_ff, base_in;
   logic                  restart_ff, restart_in;
   logic [VFillWidth-1:0] vertex_fill_ff, vertex_fill_in;
   logic [IFillWidth-1:0] index_fill_ff, index_fill_in;
   bqe_rsp_type           rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   bqe_ctl_type           ctl;
   bqe_rsp_type           corner_beat;
   logic                  load_rsp;
   logic                  last_load;
   logic                  req_take;
   logic                  restart_now;
   logic [VFillWidth-1:0] vbase;
   logic [IFillWidth-1:0] ibase;

   bqe_corner u_corner (
      .sprite     (sprite_ff),
      .ctl        (ctl),
      .corner_out (corner_beat)
   );

   always_comb begin
      ctl.corner  = corner_ff;
      ctl.base    = base_ff;
      ctl.restart = restart_ff;

      load_rsp  = sprite_valid_ff && (!rsp_valid_ff || !rsp_stall);
      last_load = load_rsp && (corner_ff == CORNER_PLUS_MINUS);
      req_stall = sprite_valid_ff && !last_load;
      req_take  = req_valid && !req_stall;

      restart_now = ({1'b0, vertex_fill_ff} + {1'b0, QUAD_VERTS} >= VCap) ||
                    ({1'b0, index_fill_ff} + {1'b0, QUAD_INDICES} >= ICap);
      vbase = restart_now ? '0 : vertex_fill_ff;
      ibase = restart_now ? '0 : index_fill_ff;

      sprite_in       = req_take ? req_payload : sprite_ff;
      base_in         = req_take ? SlotWidth'(vbase) : base_ff;
      restart_in      = req_take ? restart_now : restart_ff;
      vertex_fill_in  = req_take ? vbase + QUAD_VERTS : vertex_fill_ff;
      index_fill_in   = req_take ? ibase + QUAD_INDICES : index_fill_ff;

      if (req_take) begin
         sprite_valid_in = 1'b1;
      end else if (last_load) begin
         sprite_valid_in = 1'b0;
      end else begin
         sprite_valid_in = sprite_valid_ff;
      end

      corner_in    = load_rsp ? corner_ff + 2'd1 : corner_ff;
      rsp_in       = load_rsp ? corner_beat : rsp_ff;
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_valid_ff <= 1'b0;
         corner_ff       <= CORNER_PLUS_PLUS;
         vertex_fill_ff  <= '0;
         index_fill_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sprite_valid_ff <= sprite_valid_in;
         corner_ff       <= corner_in;
         vertex_fill_ff  <= vertex_fill_in;
         index_fill_ff   <= index_fill_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sprite_ff  <= sprite_in;
      base_ff    <= base_in;
      restart_ff <= restart_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The corner counter only moves while a sprite is held.
   a_corner_idle: assert property (@(posedge clock) disable iff (reset)
      !sprite_valid_ff |-> corner_ff == CORNER_PLUS_PLUS)
      else $error("corner counter not at first corner with no sprite held");

   // Quads are placed on whole groups of four vertex slots.
   a_fill_aligned: assert property (@(posedge clock) disable iff (reset)
      vertex_fill_ff[1:0] == 2'b00)
      else $error("vertex fill not a multiple of four");

   // After placing a quad the fill counts stay below capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, vertex_fill_ff} < VCap) && ({1'b0, index_fill_ff} < ICap))
      else $error("fill count reached capacity");

   // A taken fourth corner is never followed at once by another fourth corner.
   a_last_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.last_corner
      |=> !(rsp_valid && rsp_payload.last_corner))
      else $error("two fourth corners in consecutive cycles");

   // A restart flag only rides on a beat that also carries the first triangle.
   a_restart_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.restarted
      |-> rsp_payload.tri_valid && rsp_payload.tri_first == '0)
      else $error("restart flagged away from a first corner at slot zero");

endmodule

### dv/bqe_checker.sv
// Checker for the billboard quad expander: predicts the four corner beats per sprite and compares.
module bqe_checker #(
   parameter int VERTEX_CAPACITY = 1024,
   parameter int INDEX_CAPACITY  = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  bqe_pkg::bqe_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bqe_pkg::bqe_rsp_type rsp_payload,
   output int                   fault_total,
   output int                   backlog
);
   import bqe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CoordMax = 2147483647;
   localparam longint CoordMin = -CoordMax - 1;

   bqe_rsp_type           corners_due[$];
   logic [VFillWidth-1:0] vertex_fill;
   logic [IFillWidth-1:0] index_fill;
   int                    faults;

   // Each axis term enters with the sign of the corner; the sum is clamped once.
   function automatic logic signed [CoordWidth-1:0] corner_coord(
      input logic signed [CoordWidth-1:0] o, l, u,
      input logic plus_side, plus_rise);
      longint total;
      total = longint'(o) + (plus_side ? longint'(l) : -longint'(l))
                          + (plus_rise ? longint'(u) : -longint'(u));
      if (total > CoordMax) return 32'(CoordMax);
      if (total < CoordMin) return 32'(CoordMin);
      return 32'(total);
   endfunction

   function automatic void expand_sprite(input bqe_req_type s);
      bqe_rsp_type          v;
      logic [1:0]           corner;
      logic                 plus_side;
      logic                 plus_rise;
      logic                 fresh;
      logic [SlotWidth-1:0] n;
      fresh = (int'(vertex_fill) + int'(QUAD_VERTS) >= VERTEX_CAPACITY) ||
              (int'(index_fill) + int'(QUAD_INDICES) >= INDEX_CAPACITY);
      if (fresh) begin
         vertex_fill = '0;
         index_fill  = '0;
      end
      n = vertex_fill;
      for (int k = 0; k < 4; k++) begin
         corner    = 2'(k);
         plus_side = (corner == CORNER_PLUS_PLUS) || (corner == CORNER_PLUS_MINUS);
         plus_rise = (corner == CORNER_PLUS_PLUS) || (corner == CORNER_MINUS_PLUS);
         v = '0;
         v.pos_x = corner_coord(s.centre_x, s.side_x, s.rise_x, plus_side, plus_rise);
         v.pos_y = corner_coord(s.centre_y, s.side_y, s.rise_y, plus_side, plus_rise);
         v.pos_z = corner_coord(s.centre_z, s.side_z, s.rise_z, plus_side, plus_rise);
         v.tex_s = plus_side ? s.tex_s_pair[15:0] : s.tex_s_pair[31:16];
         v.tex_t = plus_rise ? s.tex_t_pair[15:0] : s.tex_t_pair[31:16];
         v.vertex_rgba = s.rgba_word;
         v.tri_valid   = plus_rise;
         if (corner == CORNER_PLUS_PLUS) begin
            v.tri_first  = n;
            v.tri_second = n + 1'b1;
            v.tri_third  = n + 2'd3;
         end else if (corner == CORNER_MINUS_PLUS) begin
            v.tri_first  = n + 2'd3;
            v.tri_second = n + 1'b1;
            v.tri_third  = n + 2'd2;
         end
         v.restarted   = fresh && (corner == CORNER_PLUS_PLUS);
         v.last_corner = (corner == CORNER_PLUS_MINUS);
         corners_due.push_back(v);
      end
      vertex_fill = vertex_fill + QUAD_VERTS;
      index_fill  = index_fill + QUAD_INDICES;
   endfunction

   function automatic void log_fault(input string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
   endfunction

   always @(posedge clock) begin
      bqe_rsp_type want;
      if (reset) begin
         vertex_fill = '0;
         index_fill  = '0;
         corners_due.delete();
      end else begin
         if (req_valid && !req_stall) expand_sprite(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (corners_due.size() == 0) begin
               log_fault($sformatf("bqe_checker: vertex beat with none due: %h", rsp_payload));
            end else begin
               want = corners_due.pop_front();
               if (rsp_payload !== want) begin
                  log_fault($sformatf({"bqe_checker: corner mismatch\n",
                     "  expected pos=(%0d,%0d,%0d) tex=(%0d,%0d) rgba=%h ",
                     "tri=%b(%0d,%0d,%0d) restarted=%b last=%b\n",
                     "  actual   pos=(%0d,%0d,%0d) tex=(%0d,%0d) rgba=%h ",
                     "tri=%b(%0d,%0d,%0d) restarted=%b last=%b"},
                     want.pos_x, want.pos_y, want.pos_z, want.tex_s, want.tex_t,
                     want.vertex_rgba, want.tri_valid, want.tri_first, want.tri_second,
                     want.tri_third, want.restarted, want.last_corner,
                     rsp_payload.pos_x, rsp_payload.pos_y, rsp_payload.pos_z,
                     rsp_payload.tex_s, rsp_payload.tex_t, rsp_payload.vertex_rgba,
                     rsp_payload.tri_valid, rsp_payload.tri_first, rsp_payload.tri_second,
                     rsp_payload.tri_third, rsp_payload.restarted,
                     rsp_payload.last_corner));
               end
            end
         end
      end
      fault_total <= faults;
      backlog     <= corners_due.size();
   end

endmodule

### dv/tb.sv
// Testbench top for the billboard quad expander: clock, reset, sprite stimulus and verdict.
module tb;
   import bqe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VertCap     = 1024;
   localparam int IdxCap      = 4096;
   localparam int RandomItems = 480;
   localparam int QuietTail   = 60;
   localparam int CycleLimit  = 200000;

   localparam logic signed [CoordWidth-1:0] TopCoord    = 32'sh7FFF_FFFF;
   localparam logic signed [CoordWidth-1:0] BottomCoord = 32'sh8000_0000;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   bqe_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   bqe_rsp_type rsp_payload;
   int          fault_total;
   int          backlog;
   int          idle_pct    = 30;

   billboard_quad_expander_top #(
      .VERTEX_CAPACITY(VertCap),
      .INDEX_CAPACITY (IdxCap)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   bqe_checker #(
      .VERTEX_CAPACITY(VertCap),
      .INDEX_CAPACITY (IdxCap)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .fault_total(fault_total),
      .backlog    (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("tb: FAIL");
      $finish;
   end

   // The vertex side holds off in bursts; the chance follows the current idling level.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic bqe_req_type sprite_of(
      input logic signed [CoordWidth-1:0] cx, cy, cz, sx, sy, sz, rx, ry, rz,
      input logic [31:0] rgba, sp, tp);
      bqe_req_type s;
      s.centre_x = cx;  s.centre_y = cy;  s.centre_z = cz;
      s.side_x   = sx;  s.side_y   = sy;  s.side_z   = sz;
      s.rise_x   = rx;  s.rise_y   = ry;  s.rise_z   = rz;
      s.rgba_word  = rgba;
      s.tex_s_pair = sp;
      s.tex_t_pair = tp;
      return s;
   endfunction

   function automatic logic signed [CoordWidth-1:0] random_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 32'(int'($urandom_range(0, 8191)) - 4096);
         4, 5, 6:    return $urandom();
         7:          return TopCoord - 32'($urandom_range(0, 255));
         8:          return BottomCoord + 32'($urandom_range(0, 255));
         default:    return $urandom_range(0, 1) ? TopCoord : BottomCoord;
      endcase
   endfunction

   function automatic logic [TexWidth-1:0] extreme_tex();
      case ($urandom_range(0, 3))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic bqe_req_type random_sprite();
      bqe_req_type s;
      s = sprite_of(random_coord(), random_coord(), random_coord(),
                    random_coord(), random_coord(), random_coord(),
                    random_coord(), random_coord(), random_coord(),
                    $urandom(), $urandom(), $urandom());
      if ($urandom_range(0, 3) == 0) s.tex_s_pair = {extreme_tex(), extreme_tex()};
      if ($urandom_range(0, 3) == 0) s.tex_t_pair = {extreme_tex(), extreme_tex()};
      return s;
   endfunction

   // Called at a rising edge; returns at the edge where the sprite beat is taken.
   task automatic send_sprite(input bqe_req_type item);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_sprite(sprite_of('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
      send_sprite(sprite_of(TopCoord, TopCoord, TopCoord, TopCoord, TopCoord, TopCoord,
                            TopCoord, TopCoord, TopCoord,
                            32'hFFFF_FFFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF));
      send_sprite(sprite_of(BottomCoord, BottomCoord, BottomCoord, BottomCoord,
                            BottomCoord, BottomCoord, BottomCoord, BottomCoord,
                            BottomCoord, 32'h0000_0000, 32'h8000_8000, 32'h8000_8000));
      send_sprite(sprite_of(TopCoord, TopCoord, TopCoord, BottomCoord, BottomCoord,
                            BottomCoord, BottomCoord, BottomCoord, BottomCoord,
                            32'h1234_5678, 32'h8000_7FFF, 32'h7FFF_8000));
      send_sprite(sprite_of(BottomCoord, BottomCoord, BottomCoord, TopCoord, TopCoord,
                            TopCoord, BottomCoord, BottomCoord, BottomCoord,
                            32'h8765_4321, 32'hFFFF_0000, 32'h0000_FFFF));
      send_sprite(sprite_of(BottomCoord, TopCoord, BottomCoord, BottomCoord, TopCoord,
                            BottomCoord, TopCoord, BottomCoord, TopCoord,
                            32'hA5A5_A5A5, 32'h0000_FFFF, 32'hFFFF_0000));
      send_sprite(sprite_of(32'sd256, -32'sd512, 32'sd1024, 32'sd128, 32'sd0, -32'sd128,
                            32'sd0, 32'sd256, 32'sd0,
                            32'h1122_3344, 32'h0800_F800, 32'h1000_0000));
      // Negating the most negative half-axis must reach the top of the range.
      send_sprite(sprite_of('0, '0, '0, BottomCoord, BottomCoord, BottomCoord,
                            '0, '0, '0, 32'h5A5A_5A5A, 32'h4000_C000, 32'hC000_4000));
      send_sprite(sprite_of(-32'sd1, -32'sd1, -32'sd1, BottomCoord, BottomCoord,
                            BottomCoord, BottomCoord, BottomCoord, BottomCoord,
                            32'hFF00_FF00, 32'h0001_FFFE, 32'hFFFE_0001));
      send_sprite(sprite_of(TopCoord, TopCoord, TopCoord, 32'sd1, 32'sd1, 32'sd1,
                            '0, '0, '0, 32'h00FF_00FF, 32'h7FFF_0000, 32'h0000_7FFF));
      send_sprite(sprite_of(BottomCoord, BottomCoord, BottomCoord, 32'sd1, 32'sd1,
                            32'sd1, 32'sd1, 32'sd1, 32'sd1,
                            32'hDEAD_BEEF, 32'h8000_0000, 32'h0000_8000));
      send_sprite(sprite_of(TopCoord, BottomCoord, '0, TopCoord, BottomCoord, '0,
                            TopCoord, BottomCoord, '0,
                            32'hC3C3_3C3C, 32'hFFFF_FFFF, 32'h0000_0000));
      repeat (8) send_sprite(random_sprite());

      for (int i = 0; i < RandomItems; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               2:       idle_pct = 30;
               default: idle_pct = 60;
            endcase
         end
         if (i >= RandomItems - QuietTail) idle_pct = 0;
         send_sprite(random_sprite());
      end
      req_valid <= 1'b0;

      while (backlog != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fault_total == 0 && backlog == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
